// ===== hw/rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, codes and the segment table of the seven-segment scan driver
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int DIGIT_COUNT_DEF = 8;
    localparam int RES_DEPTH       = 4;

    // command codes
    localparam logic [1:0] CMD_STRING    = 2'd0;
    localparam logic [1:0] CMD_SET_DIGIT = 2'd1;
    localparam logic [1:0] CMD_DOT       = 2'd2;
    localparam logic [1:0] CMD_SCAN      = 2'd3;

    // buffer operations carried into the write-back stage
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_SET_DOT = 3'd2;
    localparam logic [2:0] OP_CLR_DOT = 3'd3;
    localparam logic [2:0] OP_SCAN    = 3'd4;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] SEG_DOT       = 8'h01;

    typedef struct packed {
        logic [2:0] digit_select;
        logic [7:0] segments;
        logic       last;
    } t_res;

    // {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic [7:0] seg_lookup(input logic [3:0] v);
        logic [7:0] s;
        case (v)
            4'h0: s = 8'hFC;
            4'h1: s = 8'h60;
            4'h2: s = 8'hDA;
            4'h3: s = 8'hF2;
            4'h4: s = 8'h66;
            4'h5: s = 8'hB6;
            4'h6: s = 8'hBE;
            4'h7: s = 8'hE0;
            4'h8: s = 8'hFE;
            4'h9: s = 8'hF6;
            4'hA: s = 8'hEE;
            4'hB: s = 8'h3E;
            4'hC: s = 8'h9C;
            4'hD: s = 8'h7A;
            4'hE: s = 8'h9E;
            4'hF: s = 8'h8E;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/ssd_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ssd_cmd_if
// command channel of the seven-segment scan driver
// ----------------------------------------------------------------------------
interface ssd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       string_start;
    logic [7:0] character;
    logic [7:0] digit_index;
    logic       dot_on;

    modport source (
        output valid, command, string_start, character, digit_index, dot_on,
        input  ready
    );
    modport sink (
        input  valid, command, string_start, character, digit_index, dot_on,
        output ready
    );
endinterface

// ===== hw/rtl/ssd_res_if.sv =====
// ----------------------------------------------------------------------------
// ssd_res_if
// result channel of the seven-segment scan driver
// ----------------------------------------------------------------------------
interface ssd_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] digit_select;
    logic [7:0] segments;
    logic       last;

    modport source (
        output valid, digit_select, segments, last,
        input  ready
    );
    modport sink (
        input  valid, digit_select, segments, last,
        output ready
    );
endinterface

// ===== hw/rtl/ssd_seg_mem.sv =====
// ----------------------------------------------------------------------------
// ssd_seg_mem
// segment buffer memory, registered read, per-digit valid flags
// ----------------------------------------------------------------------------
module ssd_seg_mem
    import ssd_pkg::*;
#(
    parameter int DEPTH = DIGIT_COUNT_DEF,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // never-written digits read as blank
    assign o_rd_data = r_rd_valid ? r_rd_data : 8'h00;

endmodule

// ===== hw/rtl/ssd_res_fifo.sv =====
// ----------------------------------------------------------------------------
// ssd_res_fifo
// result queue, takes the blanking and segment results of a scan in the same cycle
// ----------------------------------------------------------------------------
module ssd_res_fifo
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_res       i_first,
    input  t_res       i_second,
    output logic [2:0] o_count,
    ssd_res_if.source  o_res
);

    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    t_res       r_q [RES_DEPTH];
    logic       pop;
    t_res       head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr]        <= i_first;
            r_q[r_wr_ptr + 2'd1] <= i_second;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push) begin
            n_count = n_count + 3'd2;
        end
        if (pop) begin
            n_count = n_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd2;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
        end
    end

    assign o_count            = r_count;
    assign o_res.valid        = (r_count != 3'd0);
    assign o_res.digit_select = head.digit_select;
    assign o_res.segments     = head.segments;
    assign o_res.last         = head.last;

endmodule

// ===== hw/rtl/seven_segment_scan_driver_top.sv =====
// a scan tick passes through the r_s1 stage register and the result queue
// before its blanking transaction is offered, the segment transaction behind it
// throughput: one command per cycle while ready is high; a scan tick adds two
// results to a four-entry queue drained at one per cycle while the sink is ready
// reset: synchronous; per-digit valid flags make the buffer read as blank,
// no clearing pass, commands accepted in the first cycle after reset
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_top
// eight-digit multiplexed display driver: string parser, digit and dot
// writes, and scan rotation around a read-modify-write segment buffer
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_top
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssd_cmd_if.sink   i_cmd,
    ssd_res_if.source o_res
);

    localparam int AW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int PW = $clog2(DIGIT_COUNT + 1);

    typedef struct packed {
        logic [2:0]    kind;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } t_op;

    logic          cmd_acc;
    logic [PW-1:0] r_wp;
    logic [PW-1:0] n_wp;
    logic          r_sf;
    logic          n_sf;
    logic [AW-1:0] r_scan;
    logic [AW-1:0] n_scan;
    logic [PW-1:0] wp0;
    logic [PW-1:0] wp_prev;
    logic          sf0;
    logic [4:0]    hex;
    logic          idx_ok;
    t_op           op;

    logic          r_s1_valid;
    t_op           r_s1;
    logic [7:0]    mem_rd;
    logic [7:0]    cur;
    logic          wr_en;
    logic [7:0]    wr_data;
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [7:0]    r_fwd_data;

    logic          push;
    t_res          res_first;
    t_res          res_second;
    logic [2:0]    res_count;
    logic [2:0]    pending;

    // ---- accept stage: parser state and buffer read
    assign pending     = (r_s1_valid && r_s1.kind == OP_SCAN) ? 3'd2 : 3'd0;
    assign i_cmd.ready = (res_count + pending) <= 3'(RES_DEPTH - 2);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    assign hex     = hex_decode(i_cmd.character);
    assign idx_ok  = i_cmd.digit_index < 8'(DIGIT_COUNT);
    assign wp0     = i_cmd.string_start ? '0 : r_wp;
    assign sf0     = i_cmd.string_start ? 1'b0 : r_sf;
    assign wp_prev = wp0 - PW'(1);

    always_comb begin
        n_wp    = r_wp;
        n_sf    = r_sf;
        n_scan  = r_scan;
        op.kind = OP_NONE;
        op.addr = '0;
        op.data = 8'h00;
        case (i_cmd.command)
            CMD_STRING: begin
                n_wp = wp0;
                n_sf = sf0;
                if (!sf0) begin
                    if (wp0 >= PW'(DIGIT_COUNT)) begin
                        n_sf = 1'b1;
                        if (i_cmd.character == CH_DOT) begin
                            op.kind = OP_SET_DOT;
                            op.addr = AW'(DIGIT_COUNT - 1);
                        end
                    end else if (i_cmd.character == CH_NUL) begin
                        n_sf = 1'b1;
                    end else if (i_cmd.character == CH_DOT) begin
                        if (wp0 != '0) begin
                            op.kind = OP_SET_DOT;
                            op.addr = wp_prev[AW-1:0];
                        end
                    end else begin
                        n_wp    = wp0 + PW'(1);
                        op.addr = wp0[AW-1:0];
                        if (i_cmd.character == CH_UNDERSCORE) begin
                            op.kind = OP_WRITE;
                        end else if (hex[4]) begin
                            op.kind = OP_WRITE;
                            op.data = seg_lookup(hex[3:0]);
                        end
                    end
                end
            end
            CMD_SET_DIGIT: begin
                op.addr = i_cmd.digit_index[AW-1:0];
                if (idx_ok && hex[4]) begin
                    op.kind = OP_WRITE;
                    op.data = seg_lookup(hex[3:0]);
                end
            end
            CMD_DOT: begin
                op.addr = i_cmd.digit_index[AW-1:0];
                if (idx_ok) begin
                    op.kind = i_cmd.dot_on ? OP_SET_DOT : OP_CLR_DOT;
                end
            end
            CMD_SCAN: begin
                op.kind = OP_SCAN;
                op.addr = r_scan;
                op.data = 8'(r_scan);
                n_scan  = (r_scan == AW'(DIGIT_COUNT - 1)) ? '0 : r_scan + AW'(1);
            end
            default: begin
                op.kind = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_sf       <= 1'b1;
            r_scan     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= cmd_acc;
            if (cmd_acc) begin
                r_wp   <= n_wp;
                r_sf   <= n_sf;
                r_scan <= n_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_s1 <= op;
        end
    end

    ssd_seg_mem #(
        .DEPTH (DIGIT_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (cmd_acc),
        .i_rd_addr (op.addr),
        .o_rd_data (mem_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1.addr),
        .i_wr_data (wr_data)
    );

    // ---- modify and write-back stage, forwarding the write of the cycle before
    assign cur = (r_fwd_valid && r_fwd_addr == r_s1.addr) ? r_fwd_data : mem_rd;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_s1.data;
        push    = 1'b0;
        case (r_s1.kind)
            OP_WRITE: begin
                wr_en = r_s1_valid;
            end
            OP_SET_DOT: begin
                wr_en   = r_s1_valid;
                wr_data = cur | SEG_DOT;
            end
            OP_CLR_DOT: begin
                wr_en   = r_s1_valid;
                wr_data = cur & ~SEG_DOT;
            end
            OP_SCAN: begin
                push = r_s1_valid;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr <= r_s1.addr;
            r_fwd_data <= wr_data;
        end
    end

    assign res_first.digit_select  = r_s1.data[2:0];
    assign res_first.segments      = 8'h00;
    assign res_first.last          = 1'b0;
    assign res_second.digit_select = r_s1.data[2:0];
    assign res_second.segments     = cur;
    assign res_second.last         = 1'b1;

    ssd_res_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_first  (res_first),
        .i_second (res_second),
        .o_count  (res_count),
        .o_res    (o_res)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_count <= 3'(RES_DEPTH))
        else $error("result queue overflow");

    a_scan_reaches_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && i_cmd.command == CMD_SCAN) |=> (push && r_s1.kind == OP_SCAN))
        else $error("scan transaction lost before write-back");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> res_count <= 3'(RES_DEPTH - 2))
        else $error("scan results pushed without room");
`endif

endmodule
